// ===== rtl/core/page_bitmap_allocator_core_macros.svh =====
// Assertion macros shared by the page bitmap allocator RTL.
`ifndef PAGE_BITMAP_ALLOCATOR_CORE_MACROS_SVH
`define PAGE_BITMAP_ALLOCATOR_CORE_MACROS_SVH

// Condition must never hold at a clock edge outside reset.
`define PBA_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define PBA_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/pba_pkg.sv =====
// Shared types, codes and constants of the page bitmap allocator.
package pba_pkg;

	localparam int PW = 21;
	localparam int IW = 20;
	localparam int KW = 3;
	localparam int SW = 2;
	localparam int OPW = 5;

	localparam int NUM_PAGES_DEF     = 1048576;
	localparam int MAP_WORD_BITS_DEF = 32;

	localparam logic [PW-1:0] LIMIT_RST = 21'd4096;
	localparam logic [PW-1:0] CSS_RST   = 21'd65536;

	localparam logic CFG_LIMIT = 1'b0;
	localparam logic CFG_CSS   = 1'b1;

	localparam logic [KW-1:0] K_ALLOC   = 3'd0;
	localparam logic [KW-1:0] K_CONTIG  = 3'd1;
	localparam logic [KW-1:0] K_FREE    = 3'd2;
	localparam logic [KW-1:0] K_RELEASE = 3'd3;
	localparam logic [KW-1:0] K_RESERVE = 3'd4;

	localparam logic [SW-1:0] ST_OK      = 2'd0;
	localparam logic [SW-1:0] ST_NOSPACE = 2'd1;
	localparam logic [SW-1:0] ST_RANGE   = 2'd2;
	localparam logic [SW-1:0] ST_ISFREE  = 2'd3;

	localparam logic [OPW-1:0] OP_NONE     = 5'd0;
	localparam logic [OPW-1:0] OP_CLR      = 5'd1;
	localparam logic [OPW-1:0] OP_LOAD     = 5'd2;
	localparam logic [OPW-1:0] OP_READ     = 5'd3;
	localparam logic [OPW-1:0] OP_A_INIT   = 5'd4;
	localparam logic [OPW-1:0] OP_A_WRAP   = 5'd5;
	localparam logic [OPW-1:0] OP_A_NEXT   = 5'd6;
	localparam logic [OPW-1:0] OP_A_TAKE   = 5'd7;
	localparam logic [OPW-1:0] OP_C_INIT   = 5'd8;
	localparam logic [OPW-1:0] OP_C_HIT    = 5'd9;
	localparam logic [OPW-1:0] OP_C_MISS   = 5'd10;
	localparam logic [OPW-1:0] OP_C_FOUND  = 5'd11;
	localparam logic [OPW-1:0] OP_MARK     = 5'd12;
	localparam logic [OPW-1:0] OP_F_INIT   = 5'd13;
	localparam logic [OPW-1:0] OP_F_CLEAR  = 5'd14;
	localparam logic [OPW-1:0] OP_R_INIT   = 5'd15;
	localparam logic [OPW-1:0] OP_R_COUNT  = 5'd16;
	localparam logic [OPW-1:0] OP_FAIL_SP  = 5'd17;
	localparam logic [OPW-1:0] OP_FAIL_RG  = 5'd18;
	localparam logic [OPW-1:0] OP_FAIL_FR  = 5'd19;
	localparam logic [OPW-1:0] OP_OUT      = 5'd20;

	typedef struct packed {
		logic [OPW-1:0] op;
		logic           accept;
	} cmd_t;

	typedef struct packed {
		logic          clr_done;
		logic [KW-1:0] kind;
		logic          phase;
		logic          ge_lim;
		logic          ge_hint;
		logic          bit_used;
		logic          k_last;
		logic          s_fits;
		logic          cnt_zero;
		logic          cnt_gt_lim;
		logic          idx_ge_lim;
		logic          rem_last;
		logic          out_free;
	} stat_t;

endpackage

// ===== rtl/core/pba_ctrl.sv =====
// Sequencer of the page bitmap allocator: steps each operation page by page.
module pba_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  pba_pkg::stat_t  st,
	output pba_pkg::cmd_t   cmd
);

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_DISP  = 4'd2;
	localparam logic [3:0] S_A_CHK = 4'd3;
	localparam logic [3:0] S_A_TST = 4'd4;
	localparam logic [3:0] S_C_CHK = 4'd5;
	localparam logic [3:0] S_C_TST = 4'd6;
	localparam logic [3:0] S_M_RD  = 4'd7;
	localparam logic [3:0] S_M_WR  = 4'd8;
	localparam logic [3:0] S_R_CNT = 4'd9;
	localparam logic [3:0] S_F_RD  = 4'd10;
	localparam logic [3:0] S_F_TST = 4'd11;
	localparam logic [3:0] S_OUT   = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d    = state_q;
		cmd.op     = pba_pkg::OP_NONE;
		cmd.accept = 1'b0;
		case (state_q)
			S_CLR: begin
				if (st.clr_done) begin
					state_d = S_IDLE;
				end else begin
					cmd.op = pba_pkg::OP_CLR;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.op     = pba_pkg::OP_LOAD;
					cmd.accept = 1'b1;
					state_d    = S_DISP;
				end
			end
			S_DISP: begin
				case (st.kind)
					pba_pkg::K_ALLOC: begin
						cmd.op  = pba_pkg::OP_A_INIT;
						state_d = S_A_CHK;
					end
					pba_pkg::K_CONTIG: begin
						if (st.cnt_zero || st.cnt_gt_lim) begin
							cmd.op  = pba_pkg::OP_FAIL_SP;
							state_d = S_OUT;
						end else begin
							cmd.op  = pba_pkg::OP_C_INIT;
							state_d = S_C_CHK;
						end
					end
					pba_pkg::K_FREE: begin
						if (st.idx_ge_lim) begin
							cmd.op  = pba_pkg::OP_FAIL_RG;
							state_d = S_OUT;
						end else begin
							cmd.op  = pba_pkg::OP_F_INIT;
							state_d = S_F_RD;
						end
					end
					pba_pkg::K_RELEASE, pba_pkg::K_RESERVE: begin
						if (st.idx_ge_lim) begin
							cmd.op  = pba_pkg::OP_FAIL_RG;
							state_d = S_OUT;
						end else if (st.cnt_zero) begin
							cmd.op  = pba_pkg::OP_FAIL_SP;
							state_d = S_OUT;
						end else begin
							cmd.op  = pba_pkg::OP_R_INIT;
							state_d = S_M_RD;
						end
					end
					default: begin
						state_d = S_OUT;
					end
				endcase
			end
			S_A_CHK: begin
				if (!st.phase && st.ge_lim) begin
					cmd.op = pba_pkg::OP_A_WRAP;
				end else if (st.phase && (st.ge_hint || st.ge_lim)) begin
					cmd.op  = pba_pkg::OP_FAIL_SP;
					state_d = S_OUT;
				end else begin
					cmd.op  = pba_pkg::OP_READ;
					state_d = S_A_TST;
				end
			end
			S_A_TST: begin
				if (st.bit_used) begin
					cmd.op  = pba_pkg::OP_A_NEXT;
					state_d = S_A_CHK;
				end else begin
					cmd.op  = pba_pkg::OP_A_TAKE;
					state_d = S_OUT;
				end
			end
			S_C_CHK: begin
				if (!st.s_fits) begin
					cmd.op  = pba_pkg::OP_FAIL_SP;
					state_d = S_OUT;
				end else begin
					cmd.op  = pba_pkg::OP_READ;
					state_d = S_C_TST;
				end
			end
			S_C_TST: begin
				if (st.bit_used) begin
					cmd.op  = pba_pkg::OP_C_MISS;
					state_d = S_C_CHK;
				end else if (st.k_last) begin
					cmd.op  = pba_pkg::OP_C_FOUND;
					state_d = S_M_RD;
				end else begin
					cmd.op  = pba_pkg::OP_C_HIT;
					state_d = S_C_CHK;
				end
			end
			S_M_RD: begin
				cmd.op  = pba_pkg::OP_READ;
				state_d = S_M_WR;
			end
			S_M_WR: begin
				cmd.op = pba_pkg::OP_MARK;
				if (!st.rem_last) begin
					state_d = S_M_RD;
				end else if (st.kind == pba_pkg::K_CONTIG) begin
					state_d = S_OUT;
				end else begin
					state_d = S_R_CNT;
				end
			end
			S_R_CNT: begin
				cmd.op  = pba_pkg::OP_R_COUNT;
				state_d = S_OUT;
			end
			S_F_RD: begin
				cmd.op  = pba_pkg::OP_READ;
				state_d = S_F_TST;
			end
			S_F_TST: begin
				cmd.op  = st.bit_used ? pba_pkg::OP_F_CLEAR : pba_pkg::OP_FAIL_FR;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (st.out_free) begin
					cmd.op  = pba_pkg::OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/pba_dp.sv =====
// Datapath of the page bitmap allocator: page map, cursors, counters, result register.
`include "page_bitmap_allocator_core_macros.svh"
module pba_dp #(
	parameter int NUM_PAGES     = pba_pkg::NUM_PAGES_DEF,
	parameter int MAP_WORD_BITS = pba_pkg::MAP_WORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pba_pkg::cmd_t           cmd,
	output pba_pkg::stat_t          st,
	input  logic [pba_pkg::KW-1:0]  kind,
	input  logic [pba_pkg::IW-1:0]  page_index,
	input  logic [pba_pkg::PW-1:0]  page_count,
	input  logic                    cfg_valid,
	input  logic                    cfg_index,
	input  logic [pba_pkg::PW-1:0]  cfg_data,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [pba_pkg::IW-1:0]  result_page,
	output logic [pba_pkg::SW-1:0]  status,
	output logic [pba_pkg::PW-1:0]  free_pages,
	output logic [pba_pkg::PW-1:0]  total_pages
);

	localparam int PW    = pba_pkg::PW;
	localparam int DEPTH = (NUM_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int AW    = $clog2(DEPTH);
	localparam int BW    = $clog2(MAP_WORD_BITS);
	localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

	logic [MAP_WORD_BITS-1:0] mem [DEPTH];
	logic [MAP_WORD_BITS-1:0] rd_q;

	logic [PW-1:0] limit_q, css_q, hint_q, free_q, total_q;
	logic [PW-1:0] cur_q, s_q, k_q, rem_q, n_q;
	logic          phase_q;
	logic [pba_pkg::KW-1:0] kind_q;
	logic [pba_pkg::IW-1:0] idx_q;
	logic [PW-1:0] cnt_q;
	logic [pba_pkg::IW-1:0] res_q;
	logic [pba_pkg::SW-1:0] st_q;
	logic [AW-1:0] clr_q;
	logic          clr_done_q;

	logic                    out_valid_q;
	logic [pba_pkg::IW-1:0]  out_page_q;
	logic [pba_pkg::SW-1:0]  out_st_q;
	logic [PW-1:0]           out_free_q, out_total_q;

	logic [PW-1:0]        lim;
	logic [PW+AW-1:0]     word_wide;
	logic [AW-1:0]        cur_addr;
	logic [BW-1:0]        cur_bit;
	logic                 wr_en, rd_en, wr_bit;
	logic [AW-1:0]        waddr;
	logic [MAP_WORD_BITS-1:0] wdata;
	logic [PW-1:0]        s_init, s_end, rng_n, lim_m_idx;
	logic [PW:0]          k_inc;

	function automatic logic [PW-1:0] sat_add(input logic [PW-1:0] a, input logic [PW-1:0] b);
		logic [PW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[PW] ? {PW{1'b1}} : s[PW-1:0];
	endfunction

	function automatic logic [PW-1:0] sat_sub(input logic [PW-1:0] a, input logic [PW-1:0] b);
		return (a >= b) ? a - b : '0;
	endfunction

	// Pool size is the register clipped to the map size
	assign lim = (32'(limit_q) > 32'(NUM_PAGES)) ? PW'(NUM_PAGES) : limit_q;

	assign word_wide = {{AW{1'b0}}, cur_q} >> BW;
	assign cur_addr  = word_wide[AW-1:0];
	assign cur_bit   = cur_q[BW-1:0];

	assign s_init    = (css_q > hint_q) ? css_q : hint_q;
	assign s_end     = s_q + cnt_q;
	assign lim_m_idx = lim - PW'(idx_q);
	assign rng_n     = (cnt_q > lim_m_idx) ? lim_m_idx : cnt_q;
	assign k_inc     = {1'b0, k_q} + {{PW{1'b0}}, 1'b1};

	always_comb begin
		wr_en  = 1'b0;
		wr_bit = 1'b1;
		rd_en  = (cmd.op == pba_pkg::OP_READ);
		case (cmd.op)
			pba_pkg::OP_CLR:     wr_en = 1'b1;
			pba_pkg::OP_A_TAKE:  wr_en = 1'b1;
			pba_pkg::OP_F_CLEAR: begin
				wr_en  = 1'b1;
				wr_bit = 1'b0;
			end
			pba_pkg::OP_MARK: begin
				wr_en  = 1'b1;
				wr_bit = (kind_q != pba_pkg::K_RELEASE);
			end
			default: wr_en = 1'b0;
		endcase
		waddr = (cmd.op == pba_pkg::OP_CLR) ? clr_q : cur_addr;
		wdata = rd_q;
		wdata[cur_bit] = wr_bit;
		if (cmd.op == pba_pkg::OP_CLR) begin
			wdata = '1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_q <= mem[cur_addr];
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= pba_pkg::LIMIT_RST;
			css_q   <= pba_pkg::CSS_RST;
		end else if (cfg_valid) begin
			if (cfg_index == pba_pkg::CFG_LIMIT) begin
				limit_q <= cfg_data;
			end else begin
				css_q <= cfg_data;
			end
		end
	end

	// Control state: counters, hint, clear sweep, result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hint_q      <= '0;
			free_q      <= '0;
			total_q     <= '0;
			phase_q     <= 1'b0;
			clr_q       <= '0;
			clr_done_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				pba_pkg::OP_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == CLR_LAST) begin
						clr_done_q <= 1'b1;
					end
				end
				pba_pkg::OP_A_INIT: phase_q <= 1'b0;
				pba_pkg::OP_A_WRAP: phase_q <= 1'b1;
				pba_pkg::OP_A_TAKE: begin
					free_q <= sat_sub(free_q, PW'(1));
					hint_q <= cur_q + PW'(1);
				end
				pba_pkg::OP_C_FOUND: begin
					free_q <= sat_sub(free_q, cnt_q);
					if (s_end > hint_q) begin
						hint_q <= s_end;
					end
				end
				pba_pkg::OP_F_CLEAR: free_q <= sat_add(free_q, PW'(1));
				pba_pkg::OP_R_COUNT: begin
					if (kind_q == pba_pkg::K_RELEASE) begin
						free_q  <= sat_add(free_q, n_q);
						total_q <= sat_add(total_q, n_q);
					end else if (free_q >= n_q) begin
						free_q <= free_q - n_q;
					end
				end
				pba_pkg::OP_OUT: out_valid_q <= 1'b1;
				default: begin
				end
			endcase
		end
	end

	// Item payload and cursors
	always_ff @(posedge clk) begin
		case (cmd.op)
			pba_pkg::OP_LOAD: begin
				kind_q <= kind;
				idx_q  <= page_index;
				cnt_q  <= page_count;
				res_q  <= '0;
				st_q   <= pba_pkg::ST_OK;
			end
			pba_pkg::OP_A_INIT: cur_q <= hint_q;
			pba_pkg::OP_A_WRAP: cur_q <= '0;
			pba_pkg::OP_A_NEXT: cur_q <= cur_q + PW'(1);
			pba_pkg::OP_A_TAKE: res_q <= cur_q[pba_pkg::IW-1:0];
			pba_pkg::OP_C_INIT: begin
				s_q   <= s_init;
				cur_q <= s_init;
				k_q   <= '0;
			end
			pba_pkg::OP_C_HIT: begin
				k_q   <= k_inc[PW-1:0];
				cur_q <= cur_q + PW'(1);
			end
			pba_pkg::OP_C_MISS: begin
				s_q   <= cur_q + PW'(1);
				cur_q <= cur_q + PW'(1);
				k_q   <= '0;
			end
			pba_pkg::OP_C_FOUND: begin
				cur_q <= s_q;
				rem_q <= cnt_q;
				res_q <= s_q[pba_pkg::IW-1:0];
			end
			pba_pkg::OP_MARK: begin
				cur_q <= cur_q + PW'(1);
				rem_q <= rem_q - PW'(1);
			end
			pba_pkg::OP_F_INIT: cur_q <= PW'(idx_q);
			pba_pkg::OP_R_INIT: begin
				cur_q <= PW'(idx_q);
				rem_q <= rng_n;
				n_q   <= rng_n;
			end
			pba_pkg::OP_FAIL_SP: st_q <= pba_pkg::ST_NOSPACE;
			pba_pkg::OP_FAIL_RG: st_q <= pba_pkg::ST_RANGE;
			pba_pkg::OP_FAIL_FR: st_q <= pba_pkg::ST_ISFREE;
			pba_pkg::OP_OUT: begin
				out_page_q  <= res_q;
				out_st_q    <= st_q;
				out_free_q  <= free_q;
				out_total_q <= total_q;
			end
			default: begin
			end
		endcase
	end

	assign st.clr_done   = clr_done_q;
	assign st.kind       = kind_q;
	assign st.phase      = phase_q;
	assign st.ge_lim     = (cur_q >= lim);
	assign st.ge_hint    = (cur_q >= hint_q);
	assign st.bit_used   = rd_q[cur_bit];
	assign st.k_last     = (k_inc == {1'b0, cnt_q});
	assign st.s_fits     = (s_q <= lim - cnt_q);
	assign st.cnt_zero   = (cnt_q == '0);
	assign st.cnt_gt_lim = (cnt_q > lim);
	assign st.idx_ge_lim = (PW'(idx_q) >= lim);
	assign st.rem_last   = (rem_q == PW'(1));
	assign st.out_free   = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign result_page = out_page_q;
	assign status      = out_st_q;
	assign free_pages  = out_free_q;
	assign total_pages = out_total_q;

	`PBA_NEVER(a_map_wr_before_clear, wr_en && !clr_done_q && cmd.op != pba_pkg::OP_CLR, "map written by an item before the clearing sweep ended")
	`PBA_NEXT(a_out_loads, cmd.op == pba_pkg::OP_OUT, out_valid_q, "result register not loaded")
	`PBA_NEXT(a_total_grows, 1'b1, total_q >= $past(total_q), "total page count went down")
	`PBA_NEVER(a_out_overwrite, cmd.op == pba_pkg::OP_OUT && out_valid_q && out_stall, "pending result overwritten")
	`PBA_NEVER(a_accept_load, cmd.accept != (cmd.op == pba_pkg::OP_LOAD), "accept strobe apart from payload load")

endmodule

// ===== rtl/core/page_bitmap_allocator_core.sv =====
// Top level of the page bitmap allocator: sequencer plus datapath.
//
//  channel  direction  handshake              payload
//  in       inbound    in_valid / in_stall    kind, page_index, page_count
//  out      outbound   out_valid / out_stall  result_page, status, free_pages, total_pages
//  cfg      inbound    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Every page looked at takes a map read, then a test or write step, through the
// single read/write port of the page map. A single-page alloc probes pages from
// the hint and may wrap once to page zero; a contiguous alloc, release or reserve
// adds a read and a write for each page marked. Free reads and tests one page.
// After reset the map is swept to all used, one word a cycle, with in_stall held
// high; cfg writes are taken. A finished result waits in the output register while
// the next transaction enters.
module page_bitmap_allocator_core #(
	parameter int NUM_PAGES     = pba_pkg::NUM_PAGES_DEF,
	parameter int MAP_WORD_BITS = pba_pkg::MAP_WORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [pba_pkg::KW-1:0]  kind,
	input  logic [pba_pkg::IW-1:0]  page_index,
	input  logic [pba_pkg::PW-1:0]  page_count,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [pba_pkg::IW-1:0]  result_page,
	output logic [pba_pkg::SW-1:0]  status,
	output logic [pba_pkg::PW-1:0]  free_pages,
	output logic [pba_pkg::PW-1:0]  total_pages,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    cfg_index,
	input  logic [pba_pkg::PW-1:0]  cfg_data
);

	pba_pkg::cmd_t  cmd;
	pba_pkg::stat_t st;

	// Registers accept a write on any cycle
	assign cfg_ready = 1'b1;

	// Sequencer: walks each transaction through read/test/write steps
	pba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// Datapath: map memory, hint, counts and the result register
	pba_dp #(
		.NUM_PAGES     (NUM_PAGES),
		.MAP_WORD_BITS (MAP_WORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.kind        (kind),
		.page_index  (page_index),
		.page_count  (page_count),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_page (result_page),
		.status      (status),
		.free_pages  (free_pages),
		.total_pages (total_pages)
	);

endmodule
